// File: hw/rtl/cia_pkg.sv
`timescale 1ns / 1ps

package cia_pkg;

  // port width of the operands and the result
  localparam int XLEN = 64;
  // width at which the arithmetic wraps, 8 to XLEN
  localparam int DATA_WIDTH = 64;
  localparam int HALF = XLEN / 2;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  localparam logic [2:0] OP_PLUS  = 3'd0;
  localparam logic [2:0] OP_MINUS = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_SUB   = 3'd3;
  localparam logic [2:0] OP_MUL   = 3'd4;
  localparam logic [2:0] OP_DIV   = 3'd5;
  localparam logic [2:0] OP_REM   = 3'd6;
  localparam logic [2:0] OP_POW   = 3'd7;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_DIVZERO = 1'b1;

  // operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    MS_AB,
    MS_ACC,
    MS_SQR
  } mul_src_t;

  // which 32x32 partial product is formed
  typedef enum logic [1:0] {
    MP_NONE,
    MP_LL,
    MP_LH,
    MP_HL
  } mul_part_t;

  typedef enum logic [1:0] {
    MA_NONE,
    MA_FIRST,
    MA_HIGH
  } mul_acc_t;

  typedef struct packed {
    logic      load;
    logic      mul_ld;
    mul_src_t  mul_src;
    mul_part_t mul_part;
    mul_acc_t  mul_acc;
    logic      wb;
    logic      expo_shift;
    logic      div_init;
    logic      div_step;
    logic      finish;
  } cia_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       b_zero;
    logic       expo_neg;
    logic       expo_zero;
    logic       expo_lsb;
    logic       expo_hi_zero;
  } cia_stat_t;

  // keep the low DATA_WIDTH bits and sign-extend them to XLEN
  function automatic logic [XLEN-1:0] wrap_dw(input logic [XLEN-1:0] x);
    logic signed [XLEN-1:0] t;
    t = $signed(x << (XLEN - DATA_WIDTH));
    return t >>> (XLEN - DATA_WIDTH);
  endfunction

  function automatic logic [XLEN-1:0] abs_val(input logic [XLEN-1:0] x);
    return x[XLEN-1] ? ('0 - x) : x;
  endfunction

endpackage

// File: hw/rtl/cia_dp.sv
`timescale 1ns / 1ps

module cia_dp
  import cia_pkg::*;
(
  input  logic                   clk,
  input  logic [2:0]             cmd,
  input  logic signed [XLEN-1:0] left_operand,
  input  logic signed [XLEN-1:0] right_operand,
  input  cia_cmd_t               ctl,
  output cia_stat_t              stat,
  output logic signed [XLEN-1:0] result_value,
  output logic                   status
);

  logic [2:0]      op;
  logic [XLEN-1:0] op_a;     // first operand, base during power
  logic [XLEN-1:0] op_b;     // second operand, exponent during power
  logic [XLEN-1:0] acc;

  logic [XLEN-1:0] mul_x;
  logic [XLEN-1:0] mul_y;
  logic [XLEN-1:0] mprod;
  logic [XLEN-1:0] mres;

  logic [XLEN-1:0] quo;
  logic [XLEN-1:0] rem;
  logic [XLEN-1:0] dvs;

  logic [XLEN:0]   rem_sh;
  logic [XLEN:0]   rem_diff;
  logic [HALF-1:0] part_x;
  logic [HALF-1:0] part_y;

  logic [XLEN-1:0] res_next;
  logic            err_next;

  assign stat.op           = op;
  assign stat.b_zero       = (op_b == '0);
  assign stat.expo_neg     = op_b[XLEN-1];
  assign stat.expo_zero    = (op_b == '0);
  assign stat.expo_lsb     = op_b[0];
  assign stat.expo_hi_zero = (op_b[XLEN-1:1] == '0);

  assign rem_sh   = {rem, quo[XLEN-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};

  always_comb begin
    case (ctl.mul_part)
      MP_LH: begin
        part_x = mul_x[HALF-1:0];
        part_y = mul_y[XLEN-1:HALF];
      end
      MP_HL: begin
        part_x = mul_x[XLEN-1:HALF];
        part_y = mul_y[HALF-1:0];
      end
      default: begin
        part_x = mul_x[HALF-1:0];
        part_y = mul_y[HALF-1:0];
      end
    endcase
  end

  always_comb begin
    res_next = op_a;
    err_next = 1'b0;
    case (op)
      OP_PLUS:  res_next = op_a;
      OP_MINUS: res_next = '0 - op_a;
      OP_ADD:   res_next = op_a + op_b;
      OP_SUB:   res_next = op_a - op_b;
      OP_MUL:   res_next = mres;
      OP_DIV: begin
        err_next = (op_b == '0);
        res_next = (op_a[XLEN-1] ^ op_b[XLEN-1]) ? ('0 - quo) : quo;
      end
      OP_REM: begin
        err_next = (op_b == '0);
        res_next = op_a[XLEN-1] ? ('0 - rem) : rem;
      end
      OP_POW: begin
        if (op_b[XLEN-1]) begin
          // negative exponent: only bases 1 and -1 give anything nonzero, and base 0 is an error
          if (op_a == '0) begin
            err_next = 1'b1;
            res_next = '0;
          end else if (op_a == XLEN'(1)) begin
            res_next = XLEN'(1);
          end else if (op_a == '1) begin
            res_next = op_b[0] ? '1 : XLEN'(1);
          end else begin
            res_next = '0;
          end
        end else begin
          res_next = acc;
        end
      end
      default: res_next = op_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op   <= cmd;
      op_a <= wrap_dw(left_operand);
      op_b <= wrap_dw(right_operand);
      acc  <= XLEN'(1);
    end

    if (ctl.mul_ld) begin
      case (ctl.mul_src)
        MS_ACC: begin
          mul_x <= acc;
          mul_y <= op_a;
        end
        MS_SQR: begin
          mul_x <= op_a;
          mul_y <= op_a;
        end
        default: begin
          mul_x <= op_a;
          mul_y <= op_b;
        end
      endcase
    end

    if (ctl.mul_part != MP_NONE) begin
      mprod <= XLEN'(part_x) * XLEN'(part_y);
    end

    case (ctl.mul_acc)
      MA_FIRST: mres <= mprod;
      MA_HIGH:  mres <= mres + {mprod[HALF-1:0], {HALF{1'b0}}};
      default:  mres <= mres;
    endcase

    if (ctl.wb) begin
      case (ctl.mul_src)
        MS_ACC:  acc  <= mres;
        MS_SQR:  op_a <= mres;
        default: acc  <= acc;
      endcase
    end

    if (ctl.expo_shift) begin
      op_b <= op_b >> 1;
    end

    if (ctl.div_init) begin
      quo <= abs_val(op_a) << (XLEN - DATA_WIDTH);
      dvs <= abs_val(op_b);
      rem <= '0;
    end else if (ctl.div_step) begin
      if (!rem_diff[XLEN]) begin
        rem <= rem_diff[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b1};
      end else begin
        rem <= rem_sh[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b0};
      end
    end

    if (ctl.finish) begin
      result_value <= err_next ? '0 : wrap_dw(res_next);
      status       <= err_next ? ST_DIVZERO : ST_OK;
    end
  end

endmodule

// File: hw/rtl/cia_ctrl.sv
`timescale 1ns / 1ps

module cia_ctrl
  import cia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  cia_stat_t stat,
  output cia_cmd_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_LD,
    S_MUL_P0,
    S_MUL_P1,
    S_MUL_P2,
    S_MUL_P3,
    S_MUL_WB,
    S_POW_TEST,
    S_DIV_INIT,
    S_DIV_RUN,
    S_FIN
  } state_t;

  state_t           state;
  mul_src_t         purpose;
  logic [CNT_W-1:0] cnt;
  logic             fin_go;

  assign in_stall = (state != S_IDLE);
  // the output register is free once its transaction completes
  assign fin_go   = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    ctl            = '0;
    ctl.mul_src    = purpose;
    ctl.load       = (state == S_IDLE) && in_valid;
    ctl.mul_ld     = (state == S_MUL_LD);
    ctl.finish     = fin_go;
    ctl.div_init   = (state == S_DIV_INIT);
    ctl.div_step   = (state == S_DIV_RUN);
    ctl.wb         = (state == S_MUL_WB);
    ctl.expo_shift = (state == S_MUL_WB) && (purpose == MS_SQR);
    case (state)
      S_MUL_P0: ctl.mul_part = MP_LL;
      S_MUL_P1: ctl.mul_part = MP_LH;
      S_MUL_P2: ctl.mul_part = MP_HL;
      default:  ctl.mul_part = MP_NONE;
    endcase
    case (state)
      S_MUL_P1: ctl.mul_acc = MA_FIRST;
      S_MUL_P2: ctl.mul_acc = MA_HIGH;
      S_MUL_P3: ctl.mul_acc = MA_HIGH;
      default:  ctl.mul_acc = MA_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      purpose   <= MS_AB;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (stat.op)
            OP_MUL: begin
              purpose <= MS_AB;
              state   <= S_MUL_LD;
            end
            OP_DIV, OP_REM: state <= stat.b_zero ? S_FIN : S_DIV_INIT;
            OP_POW: state <= stat.expo_neg ? S_FIN : S_POW_TEST;
            default: state <= S_FIN;
          endcase
        end
        S_MUL_LD: state <= S_MUL_P0;
        S_MUL_P0: state <= S_MUL_P1;
        S_MUL_P1: state <= S_MUL_P2;
        S_MUL_P2: state <= S_MUL_P3;
        S_MUL_P3: state <= S_MUL_WB;
        S_MUL_WB: begin
          case (purpose)
            MS_ACC: begin
              // last set bit of the exponent: the square is not needed
              if (stat.expo_hi_zero) begin
                state <= S_FIN;
              end else begin
                purpose <= MS_SQR;
                state   <= S_MUL_LD;
              end
            end
            MS_SQR:  state <= S_POW_TEST;
            default: state <= S_FIN;
          endcase
        end
        S_POW_TEST: begin
          if (stat.expo_zero) begin
            state <= S_FIN;
          end else begin
            purpose <= stat.expo_lsb ? MS_ACC : MS_SQR;
            state   <= S_MUL_LD;
          end
        end
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DECODE))
    else $error("accepted transaction did not reach decode");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && out_stall) |=> (state == S_FIN && out_valid))
    else $error("result overwritten while output stalled");

  a_divzero_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && stat.b_zero && (stat.op == OP_DIV || stat.op == OP_REM))
      |=> (state == S_FIN))
    else $error("zero divisor entered the divider");

  a_square_shift: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_WB && purpose == MS_SQR) |=> (state == S_POW_TEST))
    else $error("square did not return to exponent test");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_INIT) |=> (state == S_DIV_RUN && cnt == '0))
    else $error("divider started with a stale count");

endmodule

// File: hw/rtl/checked_integer_alu.sv
`timescale 1ns / 1ps

// Signed integer ALU with division-by-zero check. One transaction at a time:
// a new operation is taken only once the previous one has reached the output
// register, which may still be waiting to be taken. Multiply uses one 32x32
// multiplier three times, divide and remainder use a restoring divider (one
// quotient bit per cycle), and power sends every square and every accumulate
// through the same multiplier. A zero divisor, or base zero with a negative
// exponent, returns status 1 with a zero result. All results wrap at
// DATA_WIDTH bits and are sign-extended.
module checked_integer_alu
  import cia_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             cmd,
  input  logic signed [XLEN-1:0] left_operand,
  input  logic signed [XLEN-1:0] right_operand,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [XLEN-1:0] result_value,
  output logic                   status
);

  cia_cmd_t  ctl;
  cia_stat_t stat;

  cia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  cia_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .left_operand  (left_operand),
    .right_operand (right_operand),
    .ctl           (ctl),
    .stat          (stat),
    .result_value  (result_value),
    .status        (status)
  );

endmodule

// File: tb/checked_integer_alu_checker.sv
`timescale 1ns / 1ps

module checked_integer_alu_checker
  import cia_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [2:0]             cmd,
  input  logic signed [XLEN-1:0] left_operand,
  input  logic signed [XLEN-1:0] right_operand,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic signed [XLEN-1:0] result_value,
  input  logic                   status,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            stat;
  } alu_result_t;

  alu_result_t results_due[$];
  int          n_bad = 0;

  // keep the low DATA_WIDTH bits as a signed number
  function automatic logic [XLEN-1:0] fit_width(input logic [XLEN-1:0] x);
    logic [XLEN-1:0] keep;
    logic [XLEN-1:0] y;
    keep = {XLEN{1'b1}} >> (XLEN - DATA_WIDTH);
    y = x & keep;
    if (y[DATA_WIDTH-1]) begin
      y = y | ~keep;
    end
    return y;
  endfunction

  function automatic alu_result_t alu_predict(input logic [2:0] op,
                                              input logic [XLEN-1:0] l,
                                              input logic [XLEN-1:0] r);
    logic [XLEN-1:0] a, b, acc, base, expo, ua, ub;
    logic            err;
    alu_result_t     res;
    a = fit_width(l);
    b = fit_width(r);
    acc = '0;
    err = 1'b0;
    case (op)
      OP_PLUS:  acc = a;
      OP_MINUS: acc = '0 - a;
      OP_ADD:   acc = a + b;
      OP_SUB:   acc = a - b;
      OP_MUL:   acc = a * b;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          err = 1'b1;
        end else begin
          ua = a[XLEN-1] ? '0 - a : a;
          ub = b[XLEN-1] ? '0 - b : b;
          if (op == OP_DIV) begin
            acc = ua / ub;
            if (a[XLEN-1] != b[XLEN-1]) acc = '0 - acc;
          end else begin
            // remainder follows the sign of the dividend
            acc = ua % ub;
            if (a[XLEN-1]) acc = '0 - acc;
          end
        end
      end
      OP_POW: begin
        if (b[XLEN-1]) begin
          if (a == '0) err = 1'b1;
          else if (a == XLEN'(1)) acc = XLEN'(1);
          else if (a == '1) acc = b[0] ? '1 : XLEN'(1);
          else acc = '0;
        end else begin
          acc = XLEN'(1);
          base = a;
          expo = b;
          while (expo != '0) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
          end
        end
      end
      default: acc = a;
    endcase
    res.value = err ? '0 : fit_width(acc);
    res.stat  = err ? ST_DIVZERO : ST_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      results_due.delete();
    end else begin
      // output side first: a result never belongs to the transaction taken this edge
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: result with nothing pending: value %0d status %0d", $realtime,
                     result_value, status);
          end
        end else begin
          want = results_due.pop_front();
          if (result_value !== want.value || status !== want.stat) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: expected value %0d status %0d, got value %0d status %0d",
                       $realtime, $signed(want.value), want.stat, result_value, status);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        results_due.push_back(alu_predict(cmd, left_operand, right_operand));
      end
    end
    fail_count  <= n_bad;
    outstanding <= results_due.size();
  end

endmodule

// File: tb/checked_integer_alu_tb.sv
`timescale 1ns / 1ps

module checked_integer_alu_tb;
  import cia_pkg::*;

  localparam logic [XLEN-1:0] MOST_NEG  = {1'b1, {(XLEN-1){1'b0}}};
  localparam logic [XLEN-1:0] MOST_POS  = {1'b0, {(XLEN-1){1'b1}}};
  localparam logic [XLEN-1:0] MINUS_ONE = {XLEN{1'b1}};
  localparam logic [XLEN-1:0] ONE       = XLEN'(1);

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [2:0]             cmd;
  logic signed [XLEN-1:0] left_operand;
  logic signed [XLEN-1:0] right_operand;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [XLEN-1:0] result_value;
  logic                   status;
  int                     fail_count;
  int                     outstanding;
  bit                     send_calm;

  checked_integer_alu dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .left_operand (left_operand),
    .right_operand(right_operand),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status       (status)
  );

  checked_integer_alu_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .left_operand (left_operand),
    .right_operand(right_operand),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .status       (status),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] v;
    int              s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = ONE;
          2: v = MINUS_ONE;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      1, 2: begin
        s = int'($urandom_range(0, 2000)) - 1000;
        v = XLEN'(s);
      end
      7, 8: begin
        v = {$urandom, $urandom} >> $urandom_range(1, XLEN - 1);
        if ($urandom_range(0, 1) == 1) v = '0 - v;
      end
      9: begin
        s = $urandom_range(0, 20);
        v = ($urandom_range(0, 1) == 1) ? MOST_NEG + XLEN'(s) : MOST_POS - XLEN'(s);
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // small exponents keep the square-and-multiply loop short
  function automatic logic [XLEN-1:0] pick_exponent();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return XLEN'($urandom_range(0, 40));
    if (sel < 80) return '0 - XLEN'($urandom_range(1, 5));
    if (sel < 90) return {1'b1, 31'($urandom), $urandom};
    if (sel < 97) return XLEN'($urandom_range(0, 65535));
    return {1'b0, 31'($urandom), $urandom};
  endfunction

  task automatic offer(input logic [2:0] op, input logic [XLEN-1:0] l,
                       input logic [XLEN-1:0] r);
    int gap;
    cmd           <= op;
    left_operand  <= l;
    right_operand <= r;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = send_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering until every transaction has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [2:0]      op;
    logic [XLEN-1:0] l, r;
    int              sel;
    int              waited;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = OP_PLUS;
    left_operand  = '0;
    right_operand = '0;
    send_calm     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(OP_PLUS, MOST_POS, MINUS_ONE);
    offer(OP_PLUS, MOST_NEG, '0);
    offer(OP_MINUS, MOST_NEG, ONE);
    offer(OP_MINUS, ONE, MOST_POS);
    offer(OP_ADD, MOST_POS, ONE);
    offer(OP_ADD, MINUS_ONE, MINUS_ONE);
    offer(OP_SUB, MOST_NEG, ONE);
    offer(OP_MUL, MOST_NEG, MINUS_ONE);
    offer(OP_MUL, MOST_POS, MOST_POS);
    offer(OP_DIV, XLEN'(7), '0 - XLEN'(2));
    offer(OP_DIV, MOST_NEG, MINUS_ONE);
    offer(OP_DIV, MOST_NEG, MOST_POS);
    offer(OP_DIV, MOST_POS, '0);
    offer(OP_REM, '0 - XLEN'(7), XLEN'(2));
    offer(OP_REM, MOST_NEG, MINUS_ONE);
    offer(OP_REM, XLEN'(5), '0);
    offer(OP_POW, '0, '0);
    offer(OP_POW, '0, MINUS_ONE);
    offer(OP_POW, ONE, '0 - XLEN'(5));
    offer(OP_POW, MINUS_ONE, '0 - XLEN'(3));
    offer(OP_POW, MINUS_ONE, MOST_NEG);
    offer(OP_POW, XLEN'(5), MINUS_ONE);
    offer(OP_POW, XLEN'(3), XLEN'(40));
    offer(OP_POW, XLEN'(2), XLEN'(63));
    offer(OP_POW, '0 - XLEN'(3), MOST_POS);
    settle();

    for (int i = 0; i < 1900; i++) begin
      if (i % 100 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if (i == 950) settle();
      op = 3'($urandom_range(0, 7));
      l  = pick_operand();
      r  = pick_operand();
      if (op == OP_DIV || op == OP_REM) begin
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
          r = '0;
        end else if (sel == 2) begin
          l = MOST_NEG;
          r = MINUS_ONE;
        end
      end else if (op == OP_POW) begin
        if ($urandom_range(0, 4) < 2) begin
          case ($urandom_range(0, 5))
            0: l = '0;
            1: l = ONE;
            2: l = MINUS_ONE;
            3: l = XLEN'(2);
            4: l = '0 - XLEN'(2);
            default: l = XLEN'(3);
          endcase
        end
        r = pick_exponent();
      end
      offer(op, l, r);
    end

    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // room for a late or extra result from a long power loop
    repeat (900) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : receiver
    int run_left;
    int taken;
    int hold_at;
    bit stalling;
    run_left  = 0;
    taken     = 0;
    hold_at   = 300;
    stalling  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) taken++;
      if (run_left > 0) begin
        run_left--;
      end else if (taken >= hold_at) begin
        // long hold-off so the block backs up into its input
        stalling = 1'b1;
        run_left = 600;
        hold_at  = hold_at + 1000;
      end else if ($urandom_range(0, 24) == 0) begin
        stalling = 1'b0;
        run_left = 200;
      end else begin
        stalling = ($urandom_range(0, 2) == 0);
        run_left = gap_len();
      end
      out_stall <= stalling;
    end
  end

  initial begin : watchdog
    #120_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
